FILE: sv/two_class_aging_packet_queue_macros.svh
// assertion macros shared by the queue checker
`ifndef TWO_CLASS_AGING_PACKET_QUEUE_MACROS_SVH
`define TWO_CLASS_AGING_PACKET_QUEUE_MACROS_SVH

// same-cycle implication, reset masked
`define TCAPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define TCAPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tcapq_pkg.sv
// shared types and constants of the two-class aging packet queue
`default_nettype none
package tcapq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CNT_W = 5;
	localparam int LEN_W = 11;
	localparam int BYTES_W = 15;
	localparam logic [15:0] MAX_LEN = 16'd1500;
	localparam logic [4:0] MAX_PKT_RST = 5'd16;
	localparam logic [31:0] MAX_DELAY_RST = 32'd10000000;

	localparam logic [2:0] ACT_ENQ = 3'd0;
	localparam logic [2:0] ACT_DEQ = 3'd1;
	localparam logic [2:0] ACT_PEEK = 3'd2;
	localparam logic [2:0] ACT_REMOVE = 3'd3;
	localparam logic [2:0] ACT_AGE = 3'd4;
	localparam logic [2:0] ACT_FLUSH = 3'd5;

	localparam logic [2:0] KIND_DONE = 3'd0;
	localparam logic [2:0] KIND_REJECT = 3'd1;
	localparam logic [2:0] KIND_GIVEN = 3'd2;
	localparam logic [2:0] KIND_EMPTY = 3'd3;
	localparam logic [2:0] KIND_DROP = 3'd4;

	localparam logic CFG_MAX_PACKETS = 1'b0;
	localparam logic CFG_MAX_DELAY = 1'b1;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] hdr;
		logic [LEN_W-1:0] len;
		logic [31:0] arr;
	} entry_t;

endpackage
`default_nettype wire

FILE: sv/tcapq_mem.sv
// entry memory: one write port, one read port with registered data
`default_nettype none
module tcapq_mem #(
	parameter int AW = 5
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire [AW-1:0]         waddr,
	input  tcapq_pkg::entry_t    wdata,
	input  wire                  re,
	input  wire [AW-1:0]         raddr,
	output tcapq_pkg::entry_t    rdata
);

	tcapq_pkg::entry_t mem_q [2**AW];
	tcapq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: sv/two_class_aging_packet_queue.sv
// two-class fifo packet queue with aging drop, sequenced over one entry memory
// flush and bad codes go straight to the final step; each stored entry of a walked class takes
// a memory read, then evaluate and compact; enqueue walks data then control and then writes,
// dequeue and peek walk control then data and then read the head, remove and age walk one class
// one item at a time: in_stall holds new items until the sequencer is idle; result stalls hold it
// reset: counts, heads and byte total clear, limits take their defaults; memory is not reset
`default_nettype none
module two_class_aging_packet_queue #(
	parameter int DEPTH = tcapq_pkg::DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// item channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  action,
	input  wire         is_control,
	input  wire  [15:0] packet_id,
	input  wire  [15:0] header_handle,
	input  wire  [15:0] packet_length,
	input  wire  [31:0] now,
	// result channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  kind,
	output logic        out_class,
	output logic [15:0] out_packet_id,
	output logic [15:0] out_header,
	output logic [10:0] out_length,
	output logic [4:0]  data_count,
	output logic [4:0]  control_count,
	output logic [14:0] queued_bytes,
	output logic        last,
	// register write channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data
);

	localparam int AW = $clog2(2 * DEPTH);
	localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = tcapq_pkg::CNT_W;
	localparam int BW = tcapq_pkg::BYTES_W;

	typedef enum logic [2:0] {
		S_IDLE, S_START, S_RD, S_EV, S_END, S_FINAL, S_DRD, S_DEV
	} state_t;

	state_t state_q;

	// captured item
	logic [2:0]  act_q;
	logic        ctl_q;
	logic [15:0] pid_q;
	logic [15:0] hdr_q;
	logic [15:0] len_q;
	logic [31:0] now_q;

	// walk control: class walked, second class pending, remove mode
	logic          wcls_q;
	logic          two_q;
	logic          rmode_q;
	logic          found_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] lim_q;

	// queue state
	logic [CW-1:0] cnt_q  [2];
	logic [HW-1:0] head_q [2];
	logic [BW-1:0] bytes_q;
	logic [CW-1:0] maxp_q;
	logic [31:0]   maxd_q;

	// result register
	logic          out_valid_q;
	logic [2:0]    kind_q;
	logic          cls_q;
	logic [15:0]   oid_q;
	logic [15:0]   ohdr_q;
	logic [10:0]   olen_q;
	logic [CW-1:0] dcnt_q;
	logic [CW-1:0] ccnt_q;
	logic [BW-1:0] obytes_q;
	logic          last_q;

	// memory ports
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	tcapq_pkg::entry_t mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	tcapq_pkg::entry_t rd;

	// ring position k of class c to a memory slot
	function automatic logic [AW-1:0] slot(input logic c, input logic [HW-1:0] head,
			input logic [CW-1:0] k);
		logic [HW:0] sum;
		logic [HW:0] r;
		sum = {1'b0, head} + (HW+1)'(k);
		r = (sum >= (HW+1)'(DEPTH)) ? sum - (HW+1)'(DEPTH) : sum;
		return c ? AW'(DEPTH) + AW'(r) : AW'(r);
	endfunction

	logic          out_free;
	logic [CW-1:0] limit;
	logic          expired;
	logic          drop_age;
	logic          hit;
	logic          keep;
	logic          enq_ok;

	// next-state of the counters, and the beat to emit
	logic [CW-1:0] cnt_d  [2];
	logic [HW-1:0] head_d [2];
	logic [BW-1:0] bytes_d;
	logic          emit_en;
	logic [2:0]    e_kind;
	logic          e_cls;
	logic [15:0]   e_id;
	logic [15:0]   e_hdr;
	logic [10:0]   e_len;
	logic          e_last;

	assign out_free = !out_valid_q || !out_stall;
	assign limit = (maxp_q < CW'(DEPTH)) ? maxp_q : CW'(DEPTH);
	assign expired = ({1'b0, rd.arr} + {1'b0, maxd_q}) <= {1'b0, now_q};
	assign drop_age = !rmode_q && expired;
	assign hit = rmode_q && !found_q && (rd.id == pid_q);
	assign keep = !drop_age && !hit;
	assign enq_ok = (len_q <= tcapq_pkg::MAX_LEN) && (cnt_q[ctl_q] < limit);

	tcapq_mem #(.AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	// memory access: walk reads, compaction writes, enqueue write, head read
	always_comb begin
		mem_re = 1'b0;
		mem_raddr = slot(wcls_q, head_q[wcls_q], k_q);
		mem_we = 1'b0;
		mem_waddr = slot(wcls_q, head_q[wcls_q], w_q);
		mem_wdata = rd;
		if (state_q == S_RD) begin
			mem_re = 1'b1;
		end
		if (state_q == S_DRD) begin
			mem_re = 1'b1;
			mem_raddr = slot(ctl_q, head_q[ctl_q], '0);
		end
		if (state_q == S_EV && keep && (w_q != k_q)) begin
			mem_we = 1'b1;
		end
		if (state_q == S_FINAL && out_free && act_q == tcapq_pkg::ACT_ENQ && enq_ok) begin
			mem_we = 1'b1;
			mem_waddr = slot(ctl_q, head_q[ctl_q], cnt_q[ctl_q]);
			mem_wdata.id = pid_q;
			mem_wdata.hdr = hdr_q;
			mem_wdata.len = len_q[10:0];
			mem_wdata.arr = now_q;
		end
	end

	// counter updates and result beat
	always_comb begin
		cnt_d = cnt_q;
		head_d = head_q;
		bytes_d = bytes_q;
		emit_en = 1'b0;
		e_kind = tcapq_pkg::KIND_DONE;
		e_cls = ctl_q;
		e_id = '0;
		e_hdr = '0;
		e_len = '0;
		e_last = 1'b1;
		unique case (state_q)
			S_EV: begin
				if ((drop_age && out_free) || hit) begin
					cnt_d[wcls_q] = cnt_q[wcls_q] - CW'(1);
					if (!wcls_q) begin
						bytes_d = bytes_q - BW'(rd.len);
					end
				end
				if (drop_age && out_free) begin
					// aged entry leaves; report it with the counts after removal
					emit_en = 1'b1;
					e_kind = tcapq_pkg::KIND_DROP;
					e_cls = wcls_q;
					e_id = rd.id;
					e_len = rd.len;
					e_last = 1'b0;
				end
			end
			S_FINAL: begin
				if (out_free) begin
					emit_en = 1'b1;
					case (act_q) inside
						tcapq_pkg::ACT_ENQ: begin
							if (enq_ok) begin
								cnt_d[ctl_q] = cnt_q[ctl_q] + CW'(1);
								if (!ctl_q) begin
									bytes_d = bytes_q + BW'(len_q);
								end
							end else begin
								e_kind = tcapq_pkg::KIND_REJECT;
							end
						end
						tcapq_pkg::ACT_DEQ, tcapq_pkg::ACT_PEEK: begin
							// nonempty: head entry is fetched first
							if (cnt_q[ctl_q] == '0) begin
								e_kind = tcapq_pkg::KIND_EMPTY;
							end else begin
								emit_en = 1'b0;
							end
						end
						tcapq_pkg::ACT_REMOVE: begin
							e_kind = found_q ? tcapq_pkg::KIND_DONE : tcapq_pkg::KIND_EMPTY;
						end
						tcapq_pkg::ACT_AGE: begin
							e_kind = tcapq_pkg::KIND_DONE;
						end
						tcapq_pkg::ACT_FLUSH: begin
							cnt_d[0] = '0;
							cnt_d[1] = '0;
							head_d[0] = '0;
							head_d[1] = '0;
							bytes_d = '0;
						end
						default: begin
							e_kind = tcapq_pkg::KIND_REJECT;
						end
					endcase
				end
			end
			S_DEV: begin
				if (out_free) begin
					emit_en = 1'b1;
					e_kind = tcapq_pkg::KIND_GIVEN;
					e_id = rd.id;
					e_hdr = rd.hdr;
					e_len = rd.len;
					if (act_q == tcapq_pkg::ACT_DEQ) begin
						head_d[ctl_q] = (head_q[ctl_q] == HW'(DEPTH - 1)) ? '0
							: head_q[ctl_q] + HW'(1);
						cnt_d[ctl_q] = cnt_q[ctl_q] - CW'(1);
						if (!ctl_q) begin
							bytes_d = bytes_q - BW'(rd.len);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, queue state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			two_q <= 1'b0;
			rmode_q <= 1'b0;
			found_q <= 1'b0;
			wcls_q <= 1'b0;
			k_q <= '0;
			w_q <= '0;
			lim_q <= '0;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			head_q[0] <= '0;
			head_q[1] <= '0;
			bytes_q <= '0;
			maxp_q <= tcapq_pkg::MAX_PKT_RST;
			maxd_q <= tcapq_pkg::MAX_DELAY_RST;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			head_q <= head_d;
			bytes_q <= bytes_d;
			// a new beat only goes in when the register is free
			if (emit_en) begin
				out_valid_q <= 1'b1;
				kind_q <= e_kind;
				cls_q <= e_cls;
				oid_q <= e_id;
				ohdr_q <= e_hdr;
				olen_q <= e_len;
				dcnt_q <= cnt_d[0];
				ccnt_q <= cnt_d[1];
				obytes_q <= bytes_d;
				last_q <= e_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tcapq_pkg::CFG_MAX_PACKETS: maxp_q <= cfg_data[CW-1:0];
					tcapq_pkg::CFG_MAX_DELAY: maxd_q <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q <= action;
						ctl_q <= is_control;
						pid_q <= packet_id;
						hdr_q <= header_handle;
						len_q <= packet_length;
						now_q <= now;
						found_q <= 1'b0;
						rmode_q <= (action == tcapq_pkg::ACT_REMOVE);
						unique case (action) inside
							// enqueue ages data then control
							tcapq_pkg::ACT_ENQ: begin
								wcls_q <= 1'b0;
								two_q <= 1'b1;
								state_q <= S_START;
							end
							// dequeue and peek age control then data
							tcapq_pkg::ACT_DEQ, tcapq_pkg::ACT_PEEK: begin
								wcls_q <= 1'b1;
								two_q <= 1'b1;
								state_q <= S_START;
							end
							tcapq_pkg::ACT_REMOVE, tcapq_pkg::ACT_AGE: begin
								wcls_q <= is_control;
								two_q <= 1'b0;
								state_q <= S_START;
							end
							default: begin
								state_q <= S_FINAL;
							end
						endcase
					end
				end
				S_START: begin
					k_q <= '0;
					w_q <= '0;
					lim_q <= cnt_q[wcls_q];
					state_q <= (cnt_q[wcls_q] == '0) ? S_END : S_RD;
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					// hold while a drop beat cannot be placed
					if (!(drop_age && !out_free)) begin
						if (hit) begin
							found_q <= 1'b1;
						end
						if (keep) begin
							w_q <= w_q + CW'(1);
						end
						k_q <= k_q + CW'(1);
						state_q <= (k_q + CW'(1) == lim_q) ? S_END : S_RD;
					end
				end
				S_END: begin
					if (two_q) begin
						two_q <= 1'b0;
						wcls_q <= !wcls_q;
						state_q <= S_START;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						state_q <= emit_en ? S_IDLE : S_DRD;
					end
				end
				S_DRD: begin
					state_q <= S_DEV;
				end
				S_DEV: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign out_class = cls_q;
	assign out_packet_id = oid_q;
	assign out_header = ohdr_q;
	assign out_length = olen_q;
	assign data_count = dcnt_q;
	assign control_count = ccnt_q;
	assign queued_bytes = obytes_q;
	assign last = last_q;

endmodule
`default_nettype wire

FILE: sv/tcapq_chk.sv
// port-level checker for the packet queue, bound to the top level
`default_nettype none
`include "two_class_aging_packet_queue_macros.svh"
module tcapq_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [2:0]  kind,
	input wire        last,
	input wire [4:0]  data_count,
	input wire [4:0]  control_count
);

	// an accepted item keeps the block busy the next cycle
	`TCAPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")

	// a stalled result beat stays offered
	`TCAPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")

	// drop reports never close an item
	`TCAPQ_ASSERT_NOW(a_drop_not_last, out_valid && kind == tcapq_pkg::KIND_DROP, !last, "drop marked last")

	// queue occupancy within the default depth
	`TCAPQ_ASSERT_NOW(a_count_range, out_valid, data_count <= 5'd16 && control_count <= 5'd16, "count overflow")

endmodule

bind two_class_aging_packet_queue tcapq_chk u_tcapq_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kind          (kind),
	.last          (last),
	.data_count    (data_count),
	.control_count (control_count)
);
`default_nettype wire
